// ----- hw/rtl/s3ls_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s3ls_pkg
// Shared widths, payload types and status codes of the symmetric 3x3 solver.
// ----------------------------------------------------------------------------
package s3ls_pkg;

  // Field format
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int THR_W     = 32;

  // Internal widths of the exact arithmetic
  localparam int PROD_W = 2 * DATA_W;          // entry times entry
  localparam int ADJ_W  = 2 * DATA_W + 1;      // adjugate element
  localparam int PP_W   = 2 * DATA_W + 1;      // split partial product
  localparam int DET_W  = 3 * DATA_W + 3;      // determinant and sums, signed
  localparam int MAG_W  = DET_W;               // magnitude of those
  localparam int NUM_W  = MAG_W + FRAC_BITS;   // scaled numerator magnitude
  localparam int CMP_W  = NUM_W + DATA_W + 1;  // divider working width

  // Queue depths
  localparam int MID_DEPTH = 8;
  localparam int OUT_DEPTH = 2;

  // Term selection for the second multiply level: entry index, adjugate index
  // entries: m00 m01 m02 b0 b1 b2; adjugate: a00 a01 a02 a11 a12 a22
  localparam int NTERM = 12;
  localparam int XSEL [NTERM] = '{0, 1, 2, 3, 4, 5, 3, 4, 5, 3, 4, 5};
  localparam int ASEL [NTERM] = '{0, 1, 2, 0, 1, 2, 1, 3, 4, 2, 4, 5};

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SINGULAR  = 2'd1,
    ST_SATURATED = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] m00;
    logic signed [DATA_W-1:0] m01;
    logic signed [DATA_W-1:0] m02;
    logic signed [DATA_W-1:0] m11;
    logic signed [DATA_W-1:0] m12;
    logic signed [DATA_W-1:0] m22;
    logic signed [DATA_W-1:0] b0;
    logic signed [DATA_W-1:0] b1;
    logic signed [DATA_W-1:0] b2;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sol_x0;
    logic signed [DATA_W-1:0] sol_x1;
    logic signed [DATA_W-1:0] sol_x2;
    status_e                  status;
  } out_item_t;

  // Classified system handed from front to back
  typedef struct packed {
    logic [MAG_W-1:0]          dmag;
    logic [2:0][NUM_W-1:0]     nmag;
    logic [2:0]                neg;
    logic                      singular;
  } mid_item_t;

endpackage
`default_nettype wire

// ----- hw/rtl/s3ls_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s3ls_fifo
// Small register queue with count-based full and empty flags.
// ----------------------------------------------------------------------------
module s3ls_fifo #(
  parameter int  DEPTH = 2,
  parameter type T     = logic
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_i,
  input  wire T     wdata_i,
  input  wire logic rd_i,
  output T          rdata_o,
  output logic      empty_o,
  output logic      full_o
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                 mem [DEPTH];
  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem[rp_q];

  // advance pointers and count
  always_comb begin
    wp_d  = do_wr ? wp_q + PTR_W'(1) : wp_q;
    rp_d  = do_rd ? rp_q + PTR_W'(1) : rp_q;
    cnt_d = cnt_q + CNT_W'(do_wr) - CNT_W'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // store word
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wp_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/s3ls_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s3ls_front
// Multiplier pipeline: adjugate, determinant and numerators, then the
// singular test and sign split. Admission is credit based on the mid queue.
// ----------------------------------------------------------------------------
module s3ls_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire s3ls_pkg::in_item_t           item_i,
  input  wire logic [s3ls_pkg::THR_W-1:0]   thr_i,
  input  wire logic                         credit_i,
  output logic                              full_o,
  output logic                              mid_wr_o,
  output s3ls_pkg::mid_item_t               mid_o
);
  import s3ls_pkg::*;

  localparam int NSTG  = 6;
  localparam int CNT_W = $clog2(MID_DEPTH + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             acc;
  logic [NSTG-1:0]  v_q;

  logic signed [DATA_W-1:0] opa [12];
  logic signed [DATA_W-1:0] opb [12];
  logic signed [PROD_W-1:0] pr_q [12];
  logic signed [DATA_W-1:0] x1_q [6];
  logic signed [ADJ_W-1:0]  adj_q [6];
  logic signed [DATA_W-1:0] x2_q [6];
  logic signed [PP_W-1:0]   lo_q [NTERM];
  logic signed [PP_W-1:0]   hi_q [NTERM];
  logic signed [DET_W-1:0]  prod_q [NTERM];
  logic signed [DET_W-1:0]  sum_q [4];
  logic                     det_neg;
  logic [MAG_W-1:0]         dmag;
  logic                     sing;
  mid_item_t                mid_q;

  // admit while the mid queue has a free slot for every word in flight
  assign acc    = push_i && !full_o;
  assign full_o = (cnt_q == CNT_W'(MID_DEPTH));
  assign cnt_d  = cnt_q + CNT_W'(acc) - CNT_W'(credit_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      v_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      v_q   <= {v_q[NSTG-2:0], acc};
    end
  end

  // first level operand pairs, two per adjugate element
  always_comb begin
    opa[0]  = item_i.m11; opb[0]  = item_i.m22;
    opa[1]  = item_i.m12; opb[1]  = item_i.m12;
    opa[2]  = item_i.m02; opb[2]  = item_i.m12;
    opa[3]  = item_i.m01; opb[3]  = item_i.m22;
    opa[4]  = item_i.m01; opb[4]  = item_i.m12;
    opa[5]  = item_i.m02; opb[5]  = item_i.m11;
    opa[6]  = item_i.m00; opb[6]  = item_i.m22;
    opa[7]  = item_i.m02; opb[7]  = item_i.m02;
    opa[8]  = item_i.m01; opb[8]  = item_i.m02;
    opa[9]  = item_i.m00; opb[9]  = item_i.m12;
    opa[10] = item_i.m00; opb[10] = item_i.m11;
    opa[11] = item_i.m01; opb[11] = item_i.m01;
  end

  // magnitude and sign of the determinant, singular test
  always_comb begin
    det_neg = sum_q[0][DET_W-1];
    dmag    = det_neg ? MAG_W'(-sum_q[0]) : MAG_W'(sum_q[0]);
    sing    = (dmag == '0) ||
              (CMP_W'(dmag) < (CMP_W'(thr_i) << (2 * FRAC_BITS)));
  end

  always_ff @(posedge clk_i) begin
    // stage 1: entry products, carry entries
    for (int i = 0; i < 12; i++) begin
      pr_q[i] <= opa[i] * opb[i];
    end
    x1_q[0] <= item_i.m00; x1_q[1] <= item_i.m01; x1_q[2] <= item_i.m02;
    x1_q[3] <= item_i.b0;  x1_q[4] <= item_i.b1;  x1_q[5] <= item_i.b2;
    // stage 2: adjugate
    for (int i = 0; i < 6; i++) begin
      adj_q[i] <= ADJ_W'(pr_q[2*i]) - ADJ_W'(pr_q[2*i+1]);
      x2_q[i]  <= x1_q[i];
    end
    // stage 3: split products, low word unsigned, high part signed
    for (int k = 0; k < NTERM; k++) begin
      lo_q[k] <= x2_q[XSEL[k]] * $signed({1'b0, adj_q[ASEL[k]][DATA_W-1:0]});
      hi_q[k] <= x2_q[XSEL[k]] * $signed(adj_q[ASEL[k]][ADJ_W-1:DATA_W]);
    end
    // stage 4: join halves
    for (int k = 0; k < NTERM; k++) begin
      prod_q[k] <= (DET_W'(hi_q[k]) <<< DATA_W) + DET_W'(lo_q[k]);
    end
    // stage 5: determinant and three numerators
    for (int j = 0; j < 4; j++) begin
      sum_q[j] <= prod_q[3*j] + prod_q[3*j+1] + prod_q[3*j+2];
    end
    // stage 6: classify
    mid_q.dmag     <= dmag;
    mid_q.singular <= sing;
    for (int l = 0; l < 3; l++) begin
      mid_q.neg[l]  <= sum_q[l+1][DET_W-1] ^ det_neg;
      mid_q.nmag[l] <= sum_q[l+1][DET_W-1] ? (NUM_W'(MAG_W'(-sum_q[l+1])) << FRAC_BITS)
                                           : (NUM_W'(MAG_W'(sum_q[l+1])) << FRAC_BITS);
    end
  end

  assign mid_wr_o = v_q[NSTG-1];
  assign mid_o    = mid_q;

endmodule
`default_nettype wire

// ----- hw/rtl/s3ls_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s3ls_back
// Three-lane pipelined restoring divider, one quotient bit per stage, then
// clamp, sign and status. Stalls as a whole while its last word cannot leave.
// ----------------------------------------------------------------------------
module s3ls_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  mid_empty_i,
  input  wire s3ls_pkg::mid_item_t   mid_i,
  output logic                       mid_rd_o,
  input  wire logic                  out_full_i,
  output logic                       out_wr_o,
  output s3ls_pkg::out_item_t        out_o
);
  import s3ls_pkg::*;

  localparam int NS = DATA_W + 1;

  logic                v_q [NS];
  logic [CMP_W-1:0]    r_q [NS][3];
  logic [DATA_W-1:0]   q_q [NS][3];
  logic                ovf_q [NS][3];
  logic                neg_q [NS][3];
  logic                sing_q [NS];
  logic [MAG_W-1:0]    d_q [NS];

  logic                adv;
  logic [CMP_W-1:0]    dk   [NS][3];
  logic                ge   [NS][3];
  logic [CMP_W-1:0]    diff [NS][3];

  logic [DATA_W-1:0]   bound [3];
  logic [DATA_W-1:0]   mag   [3];
  logic [DATA_W-1:0]   res   [3];
  logic [2:0]          sat;

  // hold everything while the last word cannot leave
  assign adv      = !(v_q[NS-1] && out_full_i);
  assign mid_rd_o = adv && !mid_empty_i;
  assign out_wr_o = adv && v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NS; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (adv) begin
      v_q[0] <= !mid_empty_i;
      for (int s = 1; s < NS; s++) begin
        v_q[s] <= v_q[s-1];
      end
    end
  end

  // trial subtract of the divisor shifted to each stage's bit
  always_comb begin
    for (int s = 0; s < NS; s++) begin
      for (int l = 0; l < 3; l++) begin
        dk[s][l]   = '0;
        ge[s][l]   = 1'b0;
        diff[s][l] = '0;
      end
    end
    for (int s = 1; s < NS; s++) begin
      for (int l = 0; l < 3; l++) begin
        dk[s][l]   = CMP_W'(d_q[s-1]) << (DATA_W - s);
        ge[s][l]   = r_q[s-1][l] >= dk[s][l];
        diff[s][l] = r_q[s-1][l] - dk[s][l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // entry: overflow when the quotient would reach 2^DATA_W
      d_q[0]    <= mid_i.dmag;
      sing_q[0] <= mid_i.singular;
      for (int l = 0; l < 3; l++) begin
        r_q[0][l]   <= CMP_W'(mid_i.nmag[l]);
        q_q[0][l]   <= '0;
        neg_q[0][l] <= mid_i.neg[l];
        ovf_q[0][l] <= CMP_W'(mid_i.nmag[l]) >= (CMP_W'(mid_i.dmag) << DATA_W);
      end
      // one quotient bit per stage
      for (int s = 1; s < NS; s++) begin
        d_q[s]    <= d_q[s-1];
        sing_q[s] <= sing_q[s-1];
        for (int l = 0; l < 3; l++) begin
          r_q[s][l]   <= ge[s][l] ? diff[s][l] : r_q[s-1][l];
          q_q[s][l]   <= q_q[s-1][l] | (ge[s][l] ? (DATA_W'(1) << (DATA_W - s)) : '0);
          neg_q[s][l] <= neg_q[s-1][l];
          ovf_q[s][l] <= ovf_q[s-1][l];
        end
      end
    end
  end

  // clamp and apply sign
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      bound[l] = neg_q[NS-1][l] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      sat[l]   = ovf_q[NS-1][l] || (q_q[NS-1][l] > bound[l]);
      mag[l]   = sat[l] ? bound[l] : q_q[NS-1][l];
      res[l]   = neg_q[NS-1][l] ? (~mag[l] + DATA_W'(1)) : mag[l];
    end
    if (sing_q[NS-1]) begin
      out_o.sol_x0 = '0;
      out_o.sol_x1 = '0;
      out_o.sol_x2 = '0;
      out_o.status = ST_SINGULAR;
    end else begin
      out_o.sol_x0 = $signed(res[0]);
      out_o.sol_x1 = $signed(res[1]);
      out_o.sol_x2 = $signed(res[2]);
      out_o.status = (sat != '0) ? ST_SATURATED : ST_OK;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/symmetric_3x3_linear_solve.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// symmetric_3x3_linear_solve
// Solves M x = b for a symmetric 3x3 matrix by Cramer's rule in Q16.16.
//
// Input queue side: drive item_i and raise push; the word is taken at an edge
// where full is low. Result queue side: while empty is low result_o holds the
// oldest result; raise pop to take it. Config: the singular threshold is
// written by valid/ready (ready is always high), by the user only while the
// block idles; the block does not enforce this. One system is taken per cycle
// while full is low. A system passes 6 multiplier stages, one mid-queue slot,
// the entry stage plus 32 quotient-bit stages of the divider, and the result
// queue. When pop is held low the divider stalls and the 8-deep mid queue
// fills; full then rises once 8 systems are in the front or queued.
// Reset empties both queues and sets the threshold to 1.
// ----------------------------------------------------------------------------
module symmetric_3x3_linear_solve (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  output logic                             full,
  input  wire s3ls_pkg::in_item_t          item_i,
  output logic                             empty,
  input  wire logic                        pop,
  output s3ls_pkg::out_item_t              result_o,
  input  wire logic                        valid,
  output logic                             ready,
  input  wire logic [s3ls_pkg::THR_W-1:0]  cfg_data_i
);
  import s3ls_pkg::*;

  logic [THR_W-1:0] thr_q;
  logic             mid_wr, mid_rd, mid_empty, mid_full;
  mid_item_t        mid_w, mid_r;
  logic             out_wr, out_full;
  out_item_t        out_w;

  // threshold register
  assign ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_W'(1);
    end else if (valid) begin
      thr_q <= cfg_data_i;
    end
  end

  s3ls_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (item_i),
    .thr_i    (thr_q),
    .credit_i (mid_rd),
    .full_o   (full),
    .mid_wr_o (mid_wr),
    .mid_o    (mid_w)
  );

  s3ls_fifo #(.DEPTH(MID_DEPTH), .T(mid_item_t)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (mid_wr),
    .wdata_i (mid_w),
    .rd_i    (mid_rd),
    .rdata_o (mid_r),
    .empty_o (mid_empty),
    .full_o  (mid_full)
  );

  s3ls_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_i       (mid_r),
    .mid_rd_o    (mid_rd),
    .out_full_i  (out_full || mid_full && 1'b0),
    .out_wr_o    (out_wr),
    .out_o       (out_w)
  );

  s3ls_fifo #(.DEPTH(OUT_DEPTH), .T(out_item_t)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (out_wr),
    .wdata_i (out_w),
    .rd_i    (pop),
    .rdata_o (result_o),
    .empty_o (empty),
    .full_o  (out_full)
  );

endmodule
`default_nettype wire
